@@ hdl/sphere_triangle_subdivider_assert.svh @@
// Assertion macros for the sphere triangle subdivider.
`ifndef SPHERE_TRIANGLE_SUBDIVIDER_ASSERT_SVH
`define SPHERE_TRIANGLE_SUBDIVIDER_ASSERT_SVH

// Same-cycle implication.
`define STS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define STS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/sts_pkg.sv @@
// Package for the sphere triangle subdivider: counts and triangle selector codes.
`timescale 1ns / 1ps
package sts_pkg;
   localparam int NUM_CORNER_FIELDS = 9;
   localparam int NUM_TRIANGLES     = 4;

   typedef enum logic [1:0] {
      TRI_APR = 2'd0,
      TRI_PQR = 2'd1,
      TRI_PBQ = 2'd2,
      TRI_RQC = 2'd3
   } tri_sel_type;
endpackage

@@ hdl/sphere_triangle_subdivider.sv @@
// Sphere triangle subdivider: midpoint pipeline and four-triangle output sequencer.
//
//  channel | dir | tdata fields (low bit up)                     | tlast
//  req     | in  | a_x a_y a_z b_x b_y b_z c_x c_y c_z           | -
//  rsp     | out | v0_x v0_y v0_z v1_x v1_y v1_z v2_x v2_y v2_z  | last_triangle
//
//  An item enters the midpoint pipeline when req_tready is high; it passes the
//  sum, square, norm, square-root and division stages, then the output register.
//  Each item leaves as four items, one per cycle while rsp_tready is high, so the
//  result channel sets the sustained input rate.
//  The pipeline advances as a whole; it holds while its last stage is full and
//  the output sequencer is still sending. Reset clears valid bits and the sequencer.
`timescale 1ns / 1ps
`include "sphere_triangle_subdivider_assert.svh"
module sphere_triangle_subdivider #(
   parameter int COORD_WIDTH = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, zero fill
   input  logic [((9*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, zero fill
   output logic [((9*COORD_WIDTH+7)/8)*8-1:0] rsp_tdata,
   output logic rsp_tlast
);
   import sts_pkg::*;

   localparam int W  = COORD_WIDTH;
   localparam int F  = COORD_WIDTH - 2;
   localparam int PS = (COORD_WIDTH > 30) ? COORD_WIDTH - 30 : 0;
   localparam int MW = W + 1 - PS;
   localparam int RW = MW + 1;
   localparam int NW = 2 * RW;
   localparam int DW = MW + F + 1;
   localparam int SQ0 = 3;
   localparam int DV0 = SQ0 + RW;
   localparam int L  = DV0 + F + 1;

   logic          en;
   logic          ser_take;
   logic [L-1:0]  vld_ff;
   logic [W-1:0]  cor_ff  [L][NUM_CORNER_FIELDS];
   logic [8:0]    neg_ff  [L];
   logic [MW-1:0] mag_ff  [L][9];
   logic [2:0]    zero_ff [L];

   logic [8:0]       neg_in;
   logic [MW-1:0]    mag_in [9];
   logic [2*MW-1:0]  sq_ff  [9];
   logic [NW-1:0]    n2_in  [3];
   logic [NW-1:0]    n2_ff  [3];

   logic [RW+1:0] srem_ff  [RW][3];
   logic [RW-1:0] sroot_ff [RW][3];
   logic [NW-1:0] snb_ff   [RW][3];
   logic [RW+1:0] srem_in  [RW][3];
   logic [RW-1:0] sroot_in [RW][3];
   logic [NW-1:0] snb_in   [RW][3];

   logic [RW-1:0] drem_ff [F+1][9];
   logic [F:0]    dq_ff   [F+1][9];
   logic [F:0]    dlo_ff  [F+1][9];
   logic [RW-1:0] dn_ff   [F+1][9];
   logic [RW-1:0] drem_in [F+1][9];
   logic [F:0]    dq_in   [F+1][9];
   logic [F:0]    dlo_in  [F+1][9];
   logic [RW-1:0] dn_in   [F+1][9];

   logic [W-1:0]  mid_in     [9];
   logic          ser_vld_ff;
   tri_sel_type   cnt_ff;
   logic [W-1:0]  ser_cor_ff [9];
   logic [W-1:0]  ser_mid_ff [9];
   logic [W-1:0]  vtx        [9];

   assign ser_take   = !ser_vld_ff || (rsp_tready && cnt_ff == TRI_RQC);
   assign en         = !vld_ff[L-1] || ser_take;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[L-2:0], req_tvalid};
      end
   end

   // Stage 0: edge sums, magnitudes, signs
   for (genvar l = 0; l < 9; l++) begin : g_sum
      localparam int UC = l;
      localparam int VC = (((l / 3) + 1) % 3) * 3 + (l % 3);
      logic signed [W:0] s;
      logic [W:0]        a;
      assign s = $signed({req_tdata[UC*W+W-1], req_tdata[UC*W +: W]})
               + $signed({req_tdata[VC*W+W-1], req_tdata[VC*W +: W]});
      assign neg_in[l] = s[W];
      assign a = s[W] ? (W+1)'(-s) : (W+1)'(s);
      assign mag_in[l] = MW'(a >> PS);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 9; k++) begin
            cor_ff[0][k] <= req_tdata[k*W +: W];
            mag_ff[0][k] <= mag_in[k];
         end
         neg_ff[0]  <= neg_in;
         zero_ff[0] <= '0;
      end
   end

   for (genvar i = 1; i < L; i++) begin : g_carry
      always_ff @(posedge clock) begin
         if (en) begin
            cor_ff[i] <= cor_ff[i-1];
            neg_ff[i] <= neg_ff[i-1];
            mag_ff[i] <= mag_ff[i-1];
            if (i == 2) begin
               for (int e = 0; e < 3; e++) begin
                  zero_ff[i][e] <= (n2_in[e] == '0);
               end
            end else begin
               zero_ff[i] <= zero_ff[i-1];
            end
         end
      end
   end

   // Stages 1 and 2: squares and squared norm
   for (genvar e = 0; e < 3; e++) begin : g_norm
      assign n2_in[e] = NW'(sq_ff[e*3]) + NW'(sq_ff[e*3+1]) + NW'(sq_ff[e*3+2]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 9; k++) begin
            sq_ff[k] <= {{MW{1'b0}}, mag_ff[0][k]} * {{MW{1'b0}}, mag_ff[0][k]};
         end
         n2_ff <= n2_in;
      end
   end

   // Integer square root, one result bit per stage
   for (genvar k = 0; k < RW; k++) begin : g_sqrt
      for (genvar e = 0; e < 3; e++) begin : g_lane
         logic [RW+1:0] rem;
         logic [RW-1:0] root;
         logic [NW-1:0] nb;
         logic [RW+3:0] trem;
         logic [RW+3:0] trial;
         logic          ge;
         if (k == 0) begin : g_first
            assign rem  = '0;
            assign root = '0;
            assign nb   = n2_ff[e];
         end else begin : g_next
            assign rem  = srem_ff[k-1][e];
            assign root = sroot_ff[k-1][e];
            assign nb   = snb_ff[k-1][e];
         end
         assign trem  = {rem, nb[NW-1:NW-2]};
         assign trial = (RW+4)'({root, 2'b01});
         assign ge    = trem >= trial;
         assign srem_in[k][e]  = ge ? (RW+2)'(trem - trial) : (RW+2)'(trem);
         assign sroot_in[k][e] = {root[RW-2:0], ge};
         assign snb_in[k][e]   = nb << 2;
      end
      always_ff @(posedge clock) begin
         if (en) begin
            srem_ff[k]  <= srem_in[k];
            sroot_ff[k] <= sroot_in[k];
            snb_ff[k]   <= snb_in[k];
         end
      end
   end

   // Rounded division of magnitude by root, one quotient bit per stage
   for (genvar j = 0; j <= F; j++) begin : g_div
      for (genvar l = 0; l < 9; l++) begin : g_lane
         logic [RW-1:0] rem;
         logic [F:0]    q;
         logic [F:0]    lo;
         logic [RW-1:0] n;
         logic [RW:0]   t;
         logic          ge;
         if (j == 0) begin : g_first
            logic [DW-1:0] d;
            assign n   = sroot_ff[RW-1][l/3];
            assign d   = DW'({mag_ff[DV0-1][l], {F{1'b0}}}) + DW'(n >> 1);
            assign rem = RW'(d >> (F+1));
            assign lo  = d[F:0];
            assign q   = '0;
         end else begin : g_next
            assign n   = dn_ff[j-1][l];
            assign rem = drem_ff[j-1][l];
            assign lo  = dlo_ff[j-1][l];
            assign q   = dq_ff[j-1][l];
         end
         assign t  = {rem, lo[F]};
         assign ge = t >= {1'b0, n};
         assign drem_in[j][l] = ge ? RW'(t - {1'b0, n}) : RW'(t);
         assign dq_in[j][l]   = {q[F-1:0], ge};
         assign dlo_in[j][l]  = lo << 1;
         assign dn_in[j][l]   = n;
      end
      always_ff @(posedge clock) begin
         if (en) begin
            drem_ff[j] <= drem_in[j];
            dq_ff[j]   <= dq_in[j];
            dlo_ff[j]  <= dlo_in[j];
            dn_ff[j]   <= dn_in[j];
         end
      end
   end

   for (genvar l = 0; l < 9; l++) begin : g_mid
      logic [F:0]   q;
      logic [F:0]   sat;
      logic [W-1:0] m;
      assign q   = dq_ff[F][l];
      assign sat = (q > (F+1)'(1) << F) ? (F+1)'(1) << F : q;
      assign m   = W'(sat);
      assign mid_in[l] = zero_ff[L-1][l/3] ? '0 : (neg_ff[L-1][l] ? W'(0) - m : m);
   end

   // Output sequencer: four triangles per item
   always_ff @(posedge clock) begin
      if (reset) begin
         ser_vld_ff <= 1'b0;
         cnt_ff     <= TRI_APR;
      end else if (ser_take) begin
         ser_vld_ff <= vld_ff[L-1];
         cnt_ff     <= TRI_APR;
      end else if (rsp_tready) begin
         cnt_ff <= tri_sel_type'(cnt_ff + 2'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (ser_take) begin
         ser_cor_ff <= cor_ff[L-1];
         ser_mid_ff <= mid_in;
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         vtx[k]   = ser_cor_ff[k];
         vtx[3+k] = ser_mid_ff[k];
         vtx[6+k] = ser_mid_ff[6+k];
      end
      unique case (cnt_ff)
         TRI_APR: begin
            for (int k = 0; k < 3; k++) begin
               vtx[k]   = ser_cor_ff[k];
               vtx[3+k] = ser_mid_ff[k];
               vtx[6+k] = ser_mid_ff[6+k];
            end
         end
         TRI_PQR: begin
            for (int k = 0; k < 3; k++) begin
               vtx[k]   = ser_mid_ff[k];
               vtx[3+k] = ser_mid_ff[3+k];
               vtx[6+k] = ser_mid_ff[6+k];
            end
         end
         TRI_PBQ: begin
            for (int k = 0; k < 3; k++) begin
               vtx[k]   = ser_mid_ff[k];
               vtx[3+k] = ser_cor_ff[3+k];
               vtx[6+k] = ser_mid_ff[3+k];
            end
         end
         TRI_RQC: begin
            for (int k = 0; k < 3; k++) begin
               vtx[k]   = ser_mid_ff[6+k];
               vtx[3+k] = ser_mid_ff[3+k];
               vtx[6+k] = ser_cor_ff[6+k];
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_tdata = '0;
      for (int k = 0; k < 9; k++) begin
         rsp_tdata[k*W +: W] = vtx[k];
      end
   end

   assign rsp_tvalid = ser_vld_ff;
   assign rsp_tlast  = (cnt_ff == TRI_RQC);

   `STS_ASSERT_NEXT(a_sel_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(cnt_ff), "sequencer moved while stalled")
   `STS_ASSERT_NOW(a_stall_cause, vld_ff[L-1] && !req_tready, ser_vld_ff && !(rsp_tready && rsp_tlast), "pipeline held without a busy sequencer")
   `STS_ASSERT_NEXT(a_wrap, rsp_tvalid && rsp_tready && rsp_tlast, cnt_ff == TRI_APR, "sequencer did not restart after last triangle")
   `STS_ASSERT_NOW(a_idle_sel, !ser_vld_ff, cnt_ff == TRI_APR, "idle sequencer off first triangle")
endmodule

@@ test/sphere_triangle_subdivider_tb.sv @@
// Testbench for the sphere triangle subdivider: directed and random triangles checked per item.
`timescale 1ns / 1ps
module sphere_triangle_subdivider_tb;
   import sts_pkg::*;

   localparam int CW         = 16;
   localparam int FRAC       = CW - 2;
   localparam int DW         = ((9 * CW + 7) / 8) * 8;
   localparam int LATENCY    = 3 + (CW + 2) + (CW - 1) + 1;
   localparam int NUM_RANDOM = 120;
   localparam int WATCHDOG   = 4000;
   localparam int ONE        = 1 << FRAC;
   localparam int HALF_DIAG  = 11585;

   typedef logic signed [CW-1:0] coord_type;
   typedef coord_type vec_type [3];

   typedef struct packed {
      logic [DW-1:0] data;
      logic          last;
   } tri_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [DW-1:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [DW-1:0] rsp_tdata;
   logic rsp_tlast;

   tri_type tri_queue [$];
   tri_type first_want;
   int      mismatches;
   int      idle_cycles;
   bit      stim_done;
   bit      hold_rsp;
   bit      paused;

   sphere_triangle_subdivider #(.COORD_WIDTH(CW)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= root + bitv) begin
            x    -= root + bitv;
            root  = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   function automatic vec_type sphere_midpoint(vec_type u, vec_type v);
      vec_type         mid;
      longint          sum;
      longint unsigned mag [3];
      bit              neg [3];
      longint unsigned norm2;
      longint unsigned len;
      longint unsigned quot;
      norm2 = 0;
      for (int i = 0; i < 3; i++) begin
         sum    = longint'(u[i]) + longint'(v[i]);
         neg[i] = sum < 0;
         mag[i] = neg[i] ? -sum : sum;
         norm2 += mag[i] * mag[i];
      end
      for (int i = 0; i < 3; i++) begin
         if (norm2 == 0) begin
            mid[i] = '0;
         end else begin
            len  = int_sqrt(norm2);
            quot = ((mag[i] << FRAC) + (len >> 1)) / len;
            if (quot > ONE) quot = ONE;
            mid[i] = neg[i] ? coord_type'(-longint'(quot)) : coord_type'(quot);
         end
      end
      return mid;
   endfunction

   function automatic logic [DW-1:0] pack_tri(vec_type x, vec_type y, vec_type z);
      logic [DW-1:0] data;
      data = '0;
      for (int i = 0; i < 3; i++) begin
         data[i*CW +: CW]       = x[i];
         data[(3+i)*CW +: CW]   = y[i];
         data[(6+i)*CW +: CW]   = z[i];
      end
      return data;
   endfunction

   task automatic predict_subdivision(logic [DW-1:0] data);
      vec_type a, b, c, p, q, r;
      tri_type t;
      for (int i = 0; i < 3; i++) begin
         a[i] = data[i*CW +: CW];
         b[i] = data[(3+i)*CW +: CW];
         c[i] = data[(6+i)*CW +: CW];
      end
      p = sphere_midpoint(a, b);
      q = sphere_midpoint(b, c);
      r = sphere_midpoint(c, a);
      for (int k = 0; k < NUM_TRIANGLES; k++) begin
         case (tri_sel_type'(k))
            TRI_APR: t.data = pack_tri(a, p, r);
            TRI_PQR: t.data = pack_tri(p, q, r);
            TRI_PBQ: t.data = pack_tri(p, b, q);
            default: t.data = pack_tri(r, q, c);
         endcase
         t.last = (tri_sel_type'(k) == TRI_RQC);
         tri_queue.push_back(t);
      end
   endtask

   function automatic logic [DW-1:0] make_tri(int ax, int ay, int az, int bx, int by,
                                              int bz, int cx, int cy, int cz);
      vec_type a, b, c;
      a = '{coord_type'(ax), coord_type'(ay), coord_type'(az)};
      b = '{coord_type'(bx), coord_type'(by), coord_type'(bz)};
      c = '{coord_type'(cx), coord_type'(cy), coord_type'(cz)};
      return pack_tri(a, b, c);
   endfunction

   function automatic coord_type random_coord();
      case ($urandom_range(0, 9))
         0: return coord_type'($urandom);
         1: return coord_type'(ONE);
         2: return coord_type'(-ONE);
         3: return '0;
         default: return coord_type'(int'($urandom_range(0, 2 * ONE)) - ONE);
      endcase
   endfunction

   function automatic logic [DW-1:0] random_triangle();
      vec_type v [3];
      for (int k = 0; k < 3; k++)
         for (int i = 0; i < 3; i++) v[k][i] = random_coord();
      if ($urandom_range(0, 7) == 0) begin
         for (int i = 0; i < 3; i++) v[1][i] = -v[0][i];
      end
      return pack_tri(v[0], v[1], v[2]);
   endfunction

   task automatic send_item(logic [DW-1:0] data);
      req_tdata  <= data;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predict_subdivision(data);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      while (tri_queue.size() != 0) @(negedge clock);
   endtask

   // stream of directed triangles: unit axes, opposite corners, extremes, overflow patterns
   logic [DW-1:0] directed [$];
   logic [DW-1:0] item;
   int            burst;

   initial begin
      req_tvalid = 1'b0;
      req_tdata  = '0;
      reset      = 1'b1;
      stim_done  = 1'b0;
      hold_rsp   = 1'b0;
      paused     = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      directed.push_back(make_tri(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));
      directed.push_back(make_tri(-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE));
      directed.push_back(make_tri(ONE, 0, 0, -ONE, 0, 0, 0, ONE, 0));
      directed.push_back(make_tri(0, ONE, 0, 0, -ONE, 0, 0, 0, -ONE));
      directed.push_back(make_tri(ONE, ONE, ONE, -ONE, -ONE, -ONE, ONE, ONE, ONE));
      directed.push_back(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_tri(32767, 32767, 32767, 32767, 32767, 32767,
                                  -32768, -32768, -32768));
      directed.push_back(make_tri(-32768, -32768, -32768, -32768, -32768, -32768,
                                  32767, 32767, 32767));
      directed.push_back(make_tri(1, 0, 0, 0, 0, 0, 0, -1, 0));
      directed.push_back(make_tri(ONE, 1, 0, ONE, 0, 1, ONE, 0, 0));
      directed.push_back(make_tri(9459, 9459, 9459, -9459, 9459, 9459, 9459, -9459, 9459));
      directed.push_back(make_tri(16383, 1, -1, 1, 16383, -1, -1, 1, 16383));
      foreach (directed[i]) send_item(directed[i]);
      req_tvalid <= 1'b0;
      wait_drained();

      // the first triangle's first result is typed in plainly: corner A and its midpoints
      send_item(make_tri(ONE, 0, 0, -ONE, 0, 0, 0, 0, ONE));
      first_want      = tri_queue.pop_front();
      first_want.data = make_tri(ONE, 0, 0, 0, 0, 0, HALF_DIAG, 0, HALF_DIAG);
      first_want.last = 1'b0;
      tri_queue.push_front(first_want);
      req_tvalid <= 1'b0;
      wait_drained();

      hold_rsp = 1'b1;
      for (int n = 0; n < NUM_RANDOM; n++) begin
         if (n >= NUM_RANDOM / 2 && !paused) begin
            paused = 1'b1;
            wait_drained();
         end
         burst = $urandom_range(1, 10);
         for (int k = 0; k < burst && n < NUM_RANDOM; k++, n++) begin
            item = random_triangle();
            send_item(item);
         end
         n--;
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      stim_done = 1'b1;
   end

   int stall_pattern;
   int hold_count;

   initial begin
      rsp_tready  = 1'b0;
      hold_count  = 0;
      @(negedge clock);
      while (1) begin
         @(negedge clock);
         if (hold_rsp && hold_count < 200) begin
            hold_count++;
            rsp_tready <= 1'b0;
         end else begin
            stall_pattern = $urandom_range(0, 15);
            rsp_tready <= (stall_pattern < 11) || ($time / 400) % 3 == 0;
         end
      end
   end

   tri_type want;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (tri_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected item: data=%h last=%b", rsp_tdata, rsp_tlast);
         end else begin
            want = tri_queue.pop_front();
            if (want.data !== rsp_tdata || want.last !== rsp_tlast) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %h last %b, got %h last %b",
                           want.data, want.last, rsp_tdata, rsp_tlast);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      mismatches = 0;
      wait (stim_done);
      while (tri_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
